[rtl/tpcbd_pkg.sv]
// types, constants and helpers shared by the two-pass city-block distance core
// no dependencies
package tpcbd_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COORD_W    = 8;
   localparam int DIM_W      = 9;
   localparam int PIX_W      = 8;
   localparam int DIST_W     = 8;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   typedef logic [1:0]        opcode_type;
   typedef logic [1:0]        status_type;
   typedef logic [1:0]        csr_index_type;
   typedef logic [DIST_W-1:0] dist_type;

   localparam opcode_type OP_LOAD = 2'd0;
   localparam opcode_type OP_RUN  = 2'd1;
   localparam opcode_type OP_READ = 2'd2;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_DONE = 2'd1;
   localparam status_type ST_ERR  = 2'd2;

   localparam csr_index_type REG_WIDTH     = 2'd0;
   localparam csr_index_type REG_HEIGHT    = 2'd1;
   localparam csr_index_type REG_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(64);
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(64);
   localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(200);
   localparam dist_type         DIST_SAT        = '1;

   // smaller neighbor plus one, saturating
   function automatic dist_type min_plus_one(input dist_type a, input dist_type b);
      dist_type m;
      m = (a < b) ? a : b;
      return (m == DIST_SAT) ? DIST_SAT : m + dist_type'(1);
   endfunction

endpackage

[rtl/two_pass_city_block_distance_core.sv]
// two-pass city-block distance transform core with frame store
// depends on tpcbd_pkg
//
// usage: pulse start with req_opcode while busy is low; one transfer per
// accepted command. load commands take pixels in raster order, threshold
// them and run the forward pass into the frame store. a run command walks
// the frame backwards and finishes the distances; read commands return
// the distance at (req_read_row, req_read_col).
// every command produces exactly one result on rsp_* for one cycle,
// marked by rsp_strobe; the receiver cannot stall it.
// load and read do a store read on acceptance, then compute or return in
// their own state (S_LOAD, S_READ); run alternates a store-read state and
// a write-back state for each pixel and stays busy until it returns to idle;
// rejected commands return their error result the cycle after acceptance
// and leave busy low.
// the store is a single memory with one write and two read ports,
// registered read data.
// reset clears control state and the register file; store contents are
// undefined until loaded. csr writes are taken any cycle (csr_ready high)
// and must only occur while idle.
module two_pass_city_block_distance_core
   import tpcbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  opcode_type          req_opcode,
   input  logic [PIX_W-1:0]    req_pixel_value,
   input  logic [COORD_W-1:0]  req_read_row,
   input  logic [COORD_W-1:0]  req_read_col,
   output logic                rsp_strobe,
   output dist_type            rsp_distance,
   output status_type          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [DIM_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_BWD_RD = 3'd3;
   localparam logic [2:0] S_BWD_WR = 3'd4;

   dist_type dist_mem [DEPTH];

   logic [2:0]          state_ff, state_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [PIX_W-1:0]    thresh_ff, thresh_in;
   logic [COORD_W-1:0]  load_row_ff, load_row_in;
   logic [COORD_W-1:0]  load_col_ff, load_col_in;
   dist_type            left_ff, left_in;
   logic                frame_ready_ff, frame_ready_in;
   logic                frame_loaded_ff, frame_loaded_in;
   logic [COORD_W-1:0]  cur_row_ff, cur_row_in;
   logic [COORD_W-1:0]  cur_col_ff, cur_col_in;
   logic                fg_ff, fg_in;
   logic                up_ok_ff, up_ok_in;
   logic                last_ff, last_in;
   dist_type            right_ff, right_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   dist_type            rsp_distance_ff, rsp_distance_in;
   status_type          rsp_status_ff, rsp_status_in;
   dist_type            rd_a_ff, rd_b_ff;

   logic [DIM_W-1:0]    w_eff, h_eff;
   logic                ld_restart;
   logic [COORD_W-1:0]  ld_row, ld_col;
   logic [COORD_W-1:0]  down_row;
   logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b, mem_waddr;
   logic                mem_we;
   dist_type            mem_wdata;
   dist_type            up_val, left_eff, load_d;
   dist_type            right_val, down_val, bwd_b, bwd_final;
   logic                accept;

   // clamp the frame size to 1..max
   assign w_eff = (width_ff == '0) ? DIM_W'(1) :
                  (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? DIM_W'(1) :
                  (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;

   assign ld_restart = ({1'b0, load_row_ff} >= h_eff) || ({1'b0, load_col_ff} >= w_eff);
   assign ld_row     = ld_restart ? '0 : load_row_ff;
   assign ld_col     = ld_restart ? '0 : load_col_ff;
   assign down_row   = cur_row_ff + COORD_W'(1);

   assign up_val   = up_ok_ff ? rd_a_ff : '0;
   assign left_eff = (cur_col_ff == '0) ? '0 : left_ff;
   assign load_d   = fg_ff ? min_plus_one(left_eff, up_val) : '0;

   assign right_val = ((DIM_W'(cur_col_ff) + DIM_W'(1)) < w_eff) ? right_ff : '0;
   assign down_val  = ((DIM_W'(cur_row_ff) + DIM_W'(1)) < h_eff) ? rd_b_ff : '0;
   assign bwd_b     = min_plus_one(right_val, down_val);
   assign bwd_final = (rd_a_ff == '0) ? '0 : ((bwd_b < rd_a_ff) ? bwd_b : rd_a_ff);

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_status   = rsp_status_ff;

   always_comb begin
      state_in        = state_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      thresh_in       = thresh_ff;
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      left_in         = left_ff;
      frame_ready_in  = frame_ready_ff;
      frame_loaded_in = frame_loaded_ff;
      cur_row_in      = cur_row_ff;
      cur_col_in      = cur_col_ff;
      fg_in           = fg_ff;
      up_ok_in        = up_ok_ff;
      last_in         = last_ff;
      right_in        = right_ff;
      rsp_strobe_in   = 1'b0;
      rsp_distance_in = '0;
      rsp_status_in   = rsp_status_ff;
      rd_addr_a       = {cur_row_ff, cur_col_ff};
      rd_addr_b       = {down_row, cur_col_ff};
      mem_we          = 1'b0;
      mem_waddr       = {cur_row_ff, cur_col_ff};
      mem_wdata       = '0;

      // register file transfer
      if (csr_valid) begin
         unique case (csr_index) inside
            REG_WIDTH, REG_HEIGHT: begin
               if (csr_index == REG_WIDTH) begin
                  width_in = csr_wdata;
               end else begin
                  height_in = csr_wdata;
               end
               load_row_in     = '0;
               load_col_in     = '0;
               left_in         = '0;
               frame_ready_in  = 1'b0;
               frame_loaded_in = 1'b0;
            end
            REG_THRESHOLD: thresh_in = csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_LOAD: begin
                     if ((ld_row == '0) && (ld_col == '0)) begin
                        frame_ready_in  = 1'b0;
                        frame_loaded_in = 1'b0;
                     end
                     cur_row_in = ld_row;
                     cur_col_in = ld_col;
                     fg_in      = (req_pixel_value > thresh_ff);
                     up_ok_in   = (ld_row != '0);
                     rd_addr_a  = {ld_row - COORD_W'(1), ld_col};
                     last_in    = 1'b0;
                     if ((DIM_W'(ld_col) + DIM_W'(1)) >= w_eff) begin
                        load_col_in = '0;
                        if ((DIM_W'(ld_row) + DIM_W'(1)) >= h_eff) begin
                           load_row_in     = '0;
                           frame_loaded_in = 1'b1;
                           last_in         = 1'b1;
                        end else begin
                           load_row_in = ld_row + COORD_W'(1);
                        end
                     end else begin
                        load_row_in = ld_row;
                        load_col_in = ld_col + COORD_W'(1);
                     end
                     state_in = S_LOAD;
                  end
                  OP_RUN: begin
                     if (frame_loaded_ff) begin
                        cur_row_in = COORD_W'(h_eff - DIM_W'(1));
                        cur_col_in = COORD_W'(w_eff - DIM_W'(1));
                        state_in   = S_BWD_RD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_ERR;
                     end
                  end
                  OP_READ: begin
                     if (frame_ready_ff && ({1'b0, req_read_row} < h_eff) &&
                         ({1'b0, req_read_col} < w_eff)) begin
                        rd_addr_a = {req_read_row, req_read_col};
                        state_in  = S_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_ERR;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_ERR;
                  end
               endcase
            end
         end
         S_LOAD: begin
            mem_we        = 1'b1;
            mem_wdata     = load_d;
            left_in       = load_d;
            rsp_strobe_in = 1'b1;
            rsp_status_in = last_ff ? ST_DONE : ST_OK;
            state_in      = S_IDLE;
         end
         S_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_distance_in = rd_a_ff;
            rsp_status_in   = ST_OK;
            state_in        = S_IDLE;
         end
         S_BWD_RD: begin
            state_in = S_BWD_WR;
         end
         S_BWD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = bwd_final;
            right_in  = bwd_final;
            if (cur_col_ff == '0) begin
               if (cur_row_ff == '0) begin
                  frame_ready_in = 1'b1;
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = ST_DONE;
                  state_in       = S_IDLE;
               end else begin
                  cur_row_in = cur_row_ff - COORD_W'(1);
                  cur_col_in = COORD_W'(w_eff - DIM_W'(1));
                  state_in   = S_BWD_RD;
               end
            end else begin
               cur_col_in = cur_col_ff - COORD_W'(1);
               state_in   = S_BWD_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         width_ff        <= WIDTH_RESET;
         height_ff       <= HEIGHT_RESET;
         thresh_ff       <= THRESHOLD_RESET;
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         left_ff         <= '0;
         frame_ready_ff  <= 1'b0;
         frame_loaded_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         thresh_ff       <= thresh_in;
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         left_ff         <= left_in;
         frame_ready_ff  <= frame_ready_in;
         frame_loaded_ff <= frame_loaded_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff      <= cur_row_in;
      cur_col_ff      <= cur_col_in;
      fg_ff           <= fg_in;
      up_ok_ff        <= up_ok_in;
      last_ff         <= last_in;
      right_ff        <= right_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_status_ff   <= rsp_status_in;
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dist_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= dist_mem[rd_addr_a];
      rd_b_ff <= dist_mem[rd_addr_b];
   end

   a_load_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_IDLE) && rsp_strobe)
      else $error("load did not finish with a result");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_LOAD) || (state_ff == S_BWD_WR)))
      else $error("store written outside load or backward pass");

   a_read_needs_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> frame_ready_ff)
      else $error("read served before backward pass finished");

   a_ready_with_done: assert property (@(posedge clock) disable iff (reset)
      $rose(frame_ready_ff) |-> (rsp_strobe && (rsp_status == ST_DONE)))
      else $error("frame ready without pass finished result");

   a_bwd_needs_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWD_WR) |-> frame_loaded_ff)
      else $error("backward pass without a loaded frame");

endmodule
